### rtl/core/egc_pkg.sv
// Shared types and constants for the encoder glitch capture block.
// Used by egc_ctrl, egc_datapath, the top level and the checker; no dependencies.
`timescale 1ns / 1ps

package egc_pkg;

  typedef struct packed {
    logic signed [31:0] position;
    logic [7:0]         servo_mode;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] dump_position;
    logic [1:0]         dump_class;
    logic               last;
  } out_item_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POST_COUNT = 2'd3;

  localparam logic signed [6:0] INIT_COUNT_RST = -7'sd5;
  localparam logic [30:0]       THRESHOLD_RST  = 31'd15000;
  localparam logic [3:0]        POST_COUNT_RST = 4'd10;

  localparam logic [1:0] CLS_O = 2'd0;
  localparam logic [1:0] CLS_T = 2'd1;
  localparam logic [1:0] CLS_S = 2'd2;
  localparam logic [7:0] MODE_T = 8'd3;

  // read source for the ring port
  localparam logic [1:0] RD_BACK1 = 2'd0;
  localparam logic [1:0] RD_BACK2 = 2'd1;
  localparam logic [1:0] RD_BACK3 = 2'd2;
  localparam logic [1:0] RD_DUMP  = 2'd3;

  // accumulator operations
  localparam logic [2:0] ACC_HOLD   = 3'd0;
  localparam logic [2:0] ACC_LOAD   = 3'd1;
  localparam logic [2:0] ACC_SUB    = 3'd2;
  localparam logic [2:0] ACC_TRIPLE = 3'd3;
  localparam logic [2:0] ACC_ADD    = 3'd4;
  localparam logic [2:0] ACC_RSUB   = 3'd5;

  localparam int ACC_W = 37;

  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic       wr;
    logic       dump_start;
    logic       rd_en;
    logic [1:0] rd_src;
    logic [2:0] acc_op;
    logic       rp_adv;
    logic       out_load;
    logic       out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic glitch;
    logic out_free;
  } dp_sts_t;

  function automatic logic [1:0] mode_class(input logic [7:0] mode);
    logic [1:0] c;
    if (mode < MODE_T) begin
      c = CLS_O;
    end else if (mode == MODE_T) begin
      c = CLS_T;
    end else begin
      c = CLS_S;
    end
    return c;
  endfunction

endpackage

### rtl/core/egc_ctrl.sv
// Sequencer for encoder glitch capture: mode counter, enable and post count
// registers, and the state machine that drives egc_datapath. Uses egc_pkg.
`timescale 1ns / 1ps

module egc_ctrl #(
  parameter int DUMP_LEN = 16,
  parameter int PRE_LEN  = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  egc_pkg::cfg_wr_t cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  egc_pkg::dp_sts_t sts,
  output egc_pkg::dp_cmd_t cmd
);

  localparam int KW = $clog2(DUMP_LEN);
  localparam logic [KW-1:0] LAST_K = KW'(DUMP_LEN - 1);
  localparam logic signed [6:0] PRE_LOAD = 7'(-PRE_LEN);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD1  = 4'd1;
  localparam logic [3:0] ST_RD2  = 4'd2;
  localparam logic [3:0] ST_RD3  = 4'd3;
  localparam logic [3:0] ST_TRI  = 4'd4;
  localparam logic [3:0] ST_ADD  = 4'd5;
  localparam logic [3:0] ST_RSUB = 4'd6;
  localparam logic [3:0] ST_CMP  = 4'd7;
  localparam logic [3:0] ST_DRD  = 4'd8;
  localparam logic [3:0] ST_DOUT = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic signed [6:0] cnt_r, cnt_nxt;
  logic              en_r, en_nxt;
  logic [3:0]        post_r, post_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic              in_accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    en_nxt    = en_r;
    post_nxt  = post_r;
    k_nxt     = k_r;
    cmd       = '0;
    cmd.acc_op = egc_pkg::ACC_HOLD;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && en_r) begin
          cmd.wr = 1'b1;
          if (cnt_r == 7'sd0) begin
            state_nxt = ST_RD1;
          end else if (cnt_r > 7'sd0) begin
            if (cnt_r == 7'sd1) begin
              cnt_nxt        = PRE_LOAD;
              cmd.dump_start = 1'b1;
              k_nxt          = '0;
              state_nxt      = ST_DRD;
            end else begin
              cnt_nxt = cnt_r - 7'sd1;
            end
          end else begin
            cnt_nxt = cnt_r + 7'sd1;
          end
        end
      end
      ST_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = egc_pkg::RD_BACK1;
        state_nxt  = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = egc_pkg::RD_BACK2;
        cmd.acc_op = egc_pkg::ACC_LOAD;
        state_nxt  = ST_RD3;
      end
      ST_RD3: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = egc_pkg::RD_BACK3;
        cmd.acc_op = egc_pkg::ACC_SUB;
        state_nxt  = ST_TRI;
      end
      ST_TRI: begin
        cmd.acc_op = egc_pkg::ACC_TRIPLE;
        state_nxt  = ST_ADD;
      end
      ST_ADD: begin
        cmd.acc_op = egc_pkg::ACC_ADD;
        state_nxt  = ST_RSUB;
      end
      ST_RSUB: begin
        cmd.acc_op = egc_pkg::ACC_RSUB;
        state_nxt  = ST_CMP;
      end
      ST_CMP: begin
        if (sts.glitch) begin
          cnt_nxt = {3'b000, post_r};
        end
        state_nxt = ST_IDLE;
      end
      ST_DRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = egc_pkg::RD_DUMP;
        state_nxt  = ST_DOUT;
      end
      ST_DOUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (k_r == LAST_K);
          cmd.rp_adv   = 1'b1;
          if (k_r == LAST_K) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_DRD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // register writes must arrive only while idle; this block does not enforce it
    if (cfg.en) begin
      case (cfg.index)
        egc_pkg::CFG_ENABLE:     en_nxt   = cfg.data[0];
        egc_pkg::CFG_INIT_COUNT: cnt_nxt  = cfg.data[6:0];
        egc_pkg::CFG_POST_COUNT: post_nxt = cfg.data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= egc_pkg::INIT_COUNT_RST;
      en_r    <= 1'b0;
      post_r  <= egc_pkg::POST_COUNT_RST;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      en_r    <= en_nxt;
      post_r  <= post_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

### rtl/core/egc_datapath.sv
// Datapath for encoder glitch capture: sample ring, pointers, prediction
// accumulator, threshold register and result register. Uses egc_pkg.
`timescale 1ns / 1ps

module egc_datapath #(
  parameter int RING_DEPTH = 16,
  parameter int DUMP_LEN   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  egc_pkg::cfg_wr_t   cfg,
  input  egc_pkg::in_item_t  in_data,
  input  egc_pkg::dp_cmd_t   cmd,
  output egc_pkg::dp_sts_t   sts,
  output logic               out_valid,
  input  logic               out_stall,
  output egc_pkg::out_item_t out_data
);

  localparam int PW  = $clog2(RING_DEPTH);
  localparam int EW  = 34;
  localparam int OFF = (DUMP_LEN - 1) % RING_DEPTH;
  localparam int AW  = egc_pkg::ACC_W;

  function automatic logic [PW-1:0] ring_sub(input logic [PW-1:0] p, input logic [PW:0] k);
    logic [PW:0] s;
    s = {1'b0, p} + (PW+1)'(RING_DEPTH) - k;
    if (s >= (PW+1)'(RING_DEPTH)) begin
      s = s - (PW+1)'(RING_DEPTH);
    end
    return s[PW-1:0];
  endfunction

  logic [EW-1:0]           ring_r [RING_DEPTH];
  logic [RING_DEPTH-1:0]   valid_r;
  logic [PW-1:0]           wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW-1:0]           wp_inc, rp_inc, rd_addr;
  logic [EW-1:0]           rd_q_r;
  logic                    rd_vld_r;
  logic signed [31:0]      rd_pos;
  logic [1:0]              rd_cls;
  logic signed [31:0]      pos_r, pos_nxt;
  logic signed [AW-1:0]    acc_r, acc_nxt, rd_ext, thr_ext;
  logic [30:0]             thr_r, thr_nxt;
  logic                    out_valid_r, out_valid_nxt;
  egc_pkg::out_item_t      out_data_r, out_data_nxt;
  logic                    init_clear;

  assign wp_inc = (wp_r == PW'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == PW'(RING_DEPTH - 1)) ? '0 : rp_r + 1'b1;

  always_comb begin
    case (cmd.rd_src)
      egc_pkg::RD_BACK1: rd_addr = ring_sub(wp_r, (PW+1)'(1));
      egc_pkg::RD_BACK2: rd_addr = ring_sub(wp_r, (PW+1)'(2));
      egc_pkg::RD_BACK3: rd_addr = ring_sub(wp_r, (PW+1)'(3));
      default:           rd_addr = rp_r;
    endcase
  end

  // entries never written since reset read as zero
  assign rd_pos = rd_vld_r ? $signed(rd_q_r[EW-1:2]) : 32'sd0;
  assign rd_cls = rd_vld_r ? rd_q_r[1:0] : egc_pkg::CLS_O;
  assign rd_ext = AW'(rd_pos);
  assign thr_ext = $signed({6'b000000, thr_r});

  assign init_clear = cfg.en && (cfg.index == egc_pkg::CFG_INIT_COUNT) &&
                      ($signed(cfg.data[6:0]) <= -DUMP_LEN);

  always_comb begin
    wp_nxt = wp_r;
    if (cmd.dump_start) begin
      wp_nxt = '0;
    end else if (cmd.wr) begin
      wp_nxt = wp_inc;
    end
    if (init_clear) begin
      wp_nxt = '0;
    end

    rp_nxt = rp_r;
    if (cmd.dump_start) begin
      rp_nxt = ring_sub(wp_inc, (PW+1)'(OFF));
    end else if (cmd.rp_adv) begin
      rp_nxt = rp_inc;
    end

    pos_nxt = cmd.wr ? in_data.position : pos_r;

    case (cmd.acc_op)
      egc_pkg::ACC_LOAD:   acc_nxt = rd_ext;
      egc_pkg::ACC_SUB:    acc_nxt = acc_r - rd_ext;
      egc_pkg::ACC_TRIPLE: acc_nxt = acc_r + (acc_r <<< 1);
      egc_pkg::ACC_ADD:    acc_nxt = acc_r + rd_ext;
      egc_pkg::ACC_RSUB:   acc_nxt = AW'(pos_r) - acc_r;
      default:             acc_nxt = acc_r;
    endcase

    thr_nxt = thr_r;
    if (cfg.en && (cfg.index == egc_pkg::CFG_THRESHOLD)) begin
      thr_nxt = cfg.data[30:0];
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (cmd.out_load) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.dump_position = rd_pos;
      out_data_nxt.dump_class    = rd_cls;
      out_data_nxt.last          = cmd.out_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign sts.glitch   = (acc_r > thr_ext) || (acc_r < -thr_ext);
  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  // ring storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      ring_r[wp_inc] <= {in_data.position, egc_pkg::mode_class(in_data.servo_mode)};
    end
    if (cmd.rd_en) begin
      rd_q_r <= ring_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      wp_r        <= '0;
      rp_r        <= '0;
      rd_vld_r    <= 1'b0;
      thr_r       <= egc_pkg::THRESHOLD_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.wr) begin
        valid_r[wp_inc] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### rtl/core/encoder_glitch_capture.sv
// Top level of the encoder glitch capture block (one axis).
// Instantiates egc_ctrl and egc_datapath; types and constants from egc_pkg.
`timescale 1ns / 1ps

// Each sample taken while enabled is written with its 2-bit mode class into a
// RING_DEPTH-entry ring. While the mode counter sits at zero the sample is
// checked against the prediction 3*(p1-p2)+p3 of the three entries before it;
// an error larger than threshold arms a countdown of post_count samples, and
// when it runs out the block sends the last DUMP_LEN ring entries, oldest
// first, with last set on the final one, then skips PRE_LEN samples before
// checking again. A sample that is ignored (enable low) or only moves the
// counter is handled in IDLE; a checked sample passes through RD1, RD2, RD3,
// TRI, ADD, RSUB and CMP, because the single ring read port fetches the three
// older entries one after another and the prediction is built by a shared
// accumulator one add per cycle; a sample that ends the countdown runs one
// ring read and one result per entry, each result waiting while out_stall is
// high. in_stall is high while a sample is being worked on. cfg_ready is
// always high; write the registers only while no sample is in progress.
module encoder_glitch_capture #(
  parameter int RING_DEPTH = 16,
  parameter int DUMP_LEN   = 16,
  parameter int PRE_LEN    = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  egc_pkg::in_item_t                   in_data,
  // dump items
  output logic                                out_valid,
  input  logic                                out_stall,
  output egc_pkg::out_item_t                  out_data,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [egc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [egc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  egc_pkg::cfg_wr_t cfg;
  egc_pkg::dp_cmd_t cmd;
  egc_pkg::dp_sts_t sts;

  // writes are taken every cycle
  assign cfg_ready = 1'b1;
  assign cfg.en    = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  egc_ctrl #(
    .DUMP_LEN (DUMP_LEN),
    .PRE_LEN  (PRE_LEN)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  egc_datapath #(
    .RING_DEPTH (RING_DEPTH),
    .DUMP_LEN   (DUMP_LEN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/core/egc_checker.sv
// Port-level checks for encoder_glitch_capture and the bind that attaches them.
// Uses egc_pkg for the result item type.
`timescale 1ns / 1ps

module egc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input egc_pkg::out_item_t out_data
);

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // samples wait while a dump is still going
  a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> in_stall)
    else $error("sample accepted in the middle of a dump");

  // only three mode classes exist
  a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.dump_class != 2'd3)
    else $error("bad mode class");

  // the first entry of a dump needs at least a ring read after the sample
  a_dump_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared one cycle after a sample");

endmodule

bind encoder_glitch_capture egc_checker u_egc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
